// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/ksl_pkg.sv -----
// Types and constants for the sorted k-smallest list.
package ksl_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    // per-cell control from the list controller
    typedef struct packed {
        logic write_en; // cell lies in the slot range touched by this insert
        logic at_top;   // cell is the highest slot touched by this insert
        logic occupied; // cell holds a kept entry
    } cell_ctrl_t;

endpackage

// ----- rtl/ksl_cell.sv -----
// One slot of the sorted list: compare against the new key, keep, shift or load.
module ksl_cell #(
    parameter int ID_BITS = 24
) (
    input  logic                          aclk,
    input  ksl_pkg::cell_ctrl_t           ctrl,
    input  logic signed [ksl_pkg::KEY_W-1:0] new_key,
    input  logic [ID_BITS-1:0]            new_id,
    input  logic                          prev_lt,
    input  logic signed [ksl_pkg::KEY_W-1:0] prev_key,
    input  logic [ID_BITS-1:0]            prev_id,
    output logic                          lt,
    output logic signed [ksl_pkg::KEY_W-1:0] key_q,
    output logic signed [ksl_pkg::KEY_W-1:0] key_d,
    output logic [ID_BITS-1:0]            id_q
);

    logic signed [ksl_pkg::KEY_W-1:0] key_reg, key_next;
    logic [ID_BITS-1:0]               id_reg, id_next;

    // new key goes before this entry (equal keys stay ahead of it)
    assign lt = ctrl.occupied && (new_key < key_reg);

    always_comb begin
        key_next = key_reg;
        id_next  = id_reg;
        if (ctrl.write_en) begin
            if (prev_lt) begin
                key_next = prev_key;
                id_next  = prev_id;
            end else if (lt || ctrl.at_top) begin
                key_next = new_key;
                id_next  = new_id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign key_q = key_reg;
    assign key_d = key_next;
    assign id_q  = id_reg;

endmodule

// ----- rtl/k_smallest_sorted_list.sv -----
// Top level of the bounded sorted list of the k smallest (id, key) pairs.
//
// Requests enter on the s_ channel (valid/ready) as func, item_id, key and
// index; one result per request leaves on the m_ channel (valid/ready).
// func selects insert, clear or read of the entry at index. Every result
// carries accepted, count, full_res and worst_key; reads also return
// entry_id and entry_key.
// The result is registered: a request taken at an edge shows its result from
// the next cycle. Throughput is one request per cycle while the receiver
// takes results, set by the row of slot cells that compare and shift in the
// same cycle. The result register frees s_ready once its content is taken,
// so a stalled receiver holds the result and blocks new requests until m_ready.
// cfg_wr_en/cfg_wr_data write the capacity (0 acts as 1, values above
// MAX_ENTRIES act as MAX_ENTRIES); write it only while idle and clear the
// list afterwards.
// Reset (aresetn low, synchronous) empties the list, sets capacity to 16 and
// drops any pending result. Slot contents are not reset.
module k_smallest_sorted_list #(
    parameter int MAX_ENTRIES = 16,
    parameter int ID_BITS     = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [23:0]        s_item_id,
    input  logic signed [31:0] s_key,
    input  logic [3:0]         s_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accepted,
    output logic [4:0]         m_count,
    output logic               m_full_res,
    output logic signed [31:0] m_worst_key,
    output logic [23:0]        m_entry_id,
    output logic signed [31:0] m_entry_key
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = ksl_pkg::KEY_W;

    logic [4:0]    cap_reg;
    logic [CW-1:0] held_count_reg, held_count_next;
    logic [CW-1:0] eff_cap, top;
    logic          in_fire, is_insert, is_clear, full_now, lt_last, insert_do;
    logic [ID_BITS-1:0] new_id;

    ksl_pkg::cell_ctrl_t ctrl [MAX_ENTRIES];
    logic                lt_vec  [MAX_ENTRIES];
    logic signed [KW-1:0] key_q  [MAX_ENTRIES];
    logic signed [KW-1:0] key_d  [MAX_ENTRIES];
    logic [ID_BITS-1:0]   id_q   [MAX_ENTRIES];

    logic                 accepted_reg, full_reg;
    logic [4:0]           count_reg;
    logic signed [KW-1:0] worst_reg, worst_next, ekey_reg, ekey_next;
    logic [23:0]          eid_reg, eid_next;
    logic                 m_valid_reg;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign is_insert = in_fire && (s_func == ksl_pkg::FUNC_INSERT);
    assign is_clear  = in_fire && (s_func == ksl_pkg::FUNC_CLEAR);
    assign new_id    = ID_BITS'(32'(s_item_id));

    always_comb begin
        if (cap_reg == 5'd0) begin
            eff_cap = CW'(1);
        end else if (32'(cap_reg) > MAX_ENTRIES) begin
            eff_cap = CW'(MAX_ENTRIES);
        end else begin
            eff_cap = CW'(cap_reg);
        end
    end

    assign full_now = held_count_reg >= eff_cap;

    // compare result of the current largest entry
    always_comb begin
        lt_last = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (32'(held_count_reg) == i + 1) lt_last = lt_vec[i];
        end
    end

    assign insert_do = is_insert && (!full_now || lt_last);
    assign top       = full_now ? held_count_reg - CW'(1) : held_count_reg;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctrl[i].write_en = insert_do && (CW'(i) <= top);
            ctrl[i].at_top   = (CW'(i) == top);
            ctrl[i].occupied = (CW'(i) < held_count_reg);
        end
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            ksl_cell #(.ID_BITS(ID_BITS)) u_cell (
                .aclk    (aclk),
                .ctrl    (ctrl[g]),
                .new_key (s_key),
                .new_id  (new_id),
                .prev_lt (1'b0),
                .prev_key(s_key),
                .prev_id (new_id),
                .lt      (lt_vec[g]),
                .key_q   (key_q[g]),
                .key_d   (key_d[g]),
                .id_q    (id_q[g])
            );
        end else begin : g_body
            ksl_cell #(.ID_BITS(ID_BITS)) u_cell (
                .aclk    (aclk),
                .ctrl    (ctrl[g]),
                .new_key (s_key),
                .new_id  (new_id),
                .prev_lt (lt_vec[g-1]),
                .prev_key(key_q[g-1]),
                .prev_id (id_q[g-1]),
                .lt      (lt_vec[g]),
                .key_q   (key_q[g]),
                .key_d   (key_d[g]),
                .id_q    (id_q[g])
            );
        end
    end

    always_comb begin
        held_count_next = held_count_reg;
        if (in_fire) begin
            case (s_func)
                ksl_pkg::FUNC_INSERT: begin
                    if (insert_do && !full_now) held_count_next = held_count_reg + CW'(1);
                end
                ksl_pkg::FUNC_CLEAR: held_count_next = '0;
                default: held_count_next = held_count_reg;
            endcase
        end
    end

    // largest key after this request, taken from the cells' next contents
    always_comb begin
        worst_next = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (32'(held_count_next) == i + 1) worst_next = key_d[i];
        end
    end

    always_comb begin
        eid_next  = '0;
        ekey_next = '0;
        if ((s_func == ksl_pkg::FUNC_READ) && (32'(s_index) < 32'(held_count_reg))) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (32'(s_index) == i) begin
                    eid_next  = 24'(32'(id_q[i]));
                    ekey_next = key_q[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg        <= 5'd16;
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) cap_reg <= cfg_wr_data;
            held_count_reg <= held_count_next;
            if (in_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            accepted_reg <= insert_do;
            count_reg    <= 5'(held_count_next);
            full_reg     <= held_count_next >= eff_cap;
            worst_reg    <= worst_next;
            eid_reg      <= eid_next;
            ekey_reg     <= ekey_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_accepted  = accepted_reg;
    assign m_count     = count_reg;
    assign m_full_res  = full_reg;
    assign m_worst_key = worst_reg;
    assign m_entry_id  = eid_reg;
    assign m_entry_key = ekey_reg;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, 32'(held_count_reg) <= MAX_ENTRIES)
    `ASSERT_IMPLY(a_accept_nonempty, aclk, aresetn, m_valid && m_accepted, m_count != 5'd0)
    `ASSERT_IMPLY(a_empty_worst, aclk, aresetn, m_valid && (m_count == 5'd0), m_worst_key == 0)
    `ASSERT_NEXT(a_clear_empties, aclk, aresetn, is_clear, held_count_reg == '0)

endmodule
